// ===== sv/lz_window_decompressor_macros.svh =====
// assertion macros shared by the lz window decompressor rtl
// no dependencies; taken in by `include where assertions are written
`ifndef LZ_WINDOW_DECOMPRESSOR_MACROS_SVH
`define LZ_WINDOW_DECOMPRESSOR_MACROS_SVH

// condition in the same cycle
`define LZWD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition in the following cycle
`define LZWD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lzwd_pkg.sv =====
// types and constants of the lz window decompressor
// no dependencies; used by scoped names from the engine, packer and top level
`default_nettype none

package lzwd_pkg;

    localparam int WINDOW_DEPTH = 256;
    localparam int PTR_W        = 8;
    localparam int DIST_W       = 9;
    localparam int BP_W         = 9;
    localparam int LEN_W        = 8;
    localparam int LIT_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int OUT_DATA_W   = 32;
    localparam int OUT_COUNT_W  = 3;

    // parser phases
    localparam logic [1:0] PH_TOKEN    = 2'd0;
    localparam logic [1:0] PH_LITERAL  = 2'd1;
    localparam logic [1:0] PH_DISTANCE = 2'd2;

    localparam logic [BYTE_W-1:0] LIT_TOKEN_MASK = 8'hC0;
    localparam logic [LEN_W-1:0]  COPY_MIN_LEN   = 8'd4;
    localparam logic [DIST_W-1:0] DIST_BASE      = 9'd256;
    localparam logic [BP_W-1:0]   BP_MAX         = 9'd256;

    // one decompressed byte on its way to the packer
    typedef struct packed {
        logic              vld;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_byte;

endpackage

`default_nettype wire

// ===== sv/lzwd_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies; read returns the old contents on a same-address write
`default_nettype none

module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// ===== sv/lzwd_engine.sv =====
// token parser, copy sequencer and history memory of the lz window decompressor
// depends on lzwd_pkg, lzwd_ram and lz_window_decompressor_macros.svh
`default_nettype none

`include "lz_window_decompressor_macros.svh"

module lzwd_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [lzwd_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic                          i_start,
    input  wire logic                          i_pack_rdy,
    output lzwd_pkg::t_byte                    o_byte
);

    localparam int PW = lzwd_pkg::PTR_W;
    localparam int BW = lzwd_pkg::BYTE_W;

    // parser state
    logic [1:0]                   r_phase;
    logic [lzwd_pkg::LIT_W-1:0]   r_lit_left;
    logic [lzwd_pkg::LEN_W-1:0]   r_code;
    // copy sequencer
    logic [lzwd_pkg::LEN_W-1:0]   r_len;
    logic [lzwd_pkg::DIST_W-1:0]  r_dist;
    logic [PW-1:0]                r_iwp;
    logic [lzwd_pkg::BP_W-1:0]    r_bp;
    // data stage, aligned with the ram read data
    logic                         r_d_vld;
    logic [PW-1:0]                r_d_addr;
    logic                         r_d_lit;
    logic [BW-1:0]                r_d_lit_byte;
    logic                         r_d_last;
    logic                         r_d_zero;
    logic                         r_d_fwd;
    logic [BW-1:0]                r_fwd_data;

    logic          adv;
    logic          busy;
    logic          acc;
    logic [1:0]    phase_eff;
    logic          lit_issue;
    logic          copy_issue;
    logic          issue;
    logic          consume;
    logic [PW-1:0] rd_addr;
    logic [BW-1:0] ram_q;
    logic [BW-1:0] d_value;
    logic          fwd_hit;

    assign adv        = !r_d_vld || i_pack_rdy;
    assign busy       = (r_len != '0);
    assign o_ready    = adv && !busy;
    assign acc        = i_valid && o_ready;
    assign phase_eff  = i_start ? lzwd_pkg::PH_TOKEN : r_phase;
    assign lit_issue  = acc && (phase_eff == lzwd_pkg::PH_LITERAL);
    assign copy_issue = adv && busy;
    assign issue      = lit_issue || copy_issue;
    assign consume    = r_d_vld && i_pack_rdy;
    assign rd_addr    = r_iwp - r_dist[PW-1:0];

    // distance one reads the byte that is being written back this cycle
    assign fwd_hit = copy_issue && consume && (rd_addr == r_d_addr);

    always_comb begin
        if (r_d_lit) begin
            d_value = r_d_lit_byte;
        end else if (r_d_zero) begin
            d_value = '0;
        end else if (r_d_fwd) begin
            d_value = r_fwd_data;
        end else begin
            d_value = ram_q;
        end
    end

    assign o_byte.vld  = r_d_vld;
    assign o_byte.data = d_value;
    assign o_byte.last = r_d_last;

    lzwd_ram #(
        .WIDTH (BW),
        .DEPTH (lzwd_pkg::WINDOW_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (consume),
        .i_waddr (r_d_addr),
        .i_wdata (d_value),
        .i_re    (copy_issue),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= lzwd_pkg::PH_TOKEN;
            r_lit_left <= '0;
            r_code     <= '0;
            r_len      <= '0;
            r_iwp      <= '0;
            r_bp       <= '0;
            r_d_vld    <= 1'b0;
            r_d_fwd    <= 1'b0;
        end else begin
            if (acc) begin
                if (i_start) begin
                    r_iwp <= '0;
                    r_bp  <= '0;
                end
                unique case (phase_eff)
                    lzwd_pkg::PH_LITERAL: begin
                        if (r_lit_left == '0) begin
                            r_phase <= lzwd_pkg::PH_TOKEN;
                        end else begin
                            r_lit_left <= r_lit_left - 1'b1;
                        end
                    end
                    lzwd_pkg::PH_DISTANCE: begin
                        r_len   <= r_code + lzwd_pkg::COPY_MIN_LEN;
                        r_dist  <= lzwd_pkg::DIST_BASE - {1'b0, i_byte};
                        r_phase <= lzwd_pkg::PH_TOKEN;
                    end
                    default: begin
                        if ((i_byte & lzwd_pkg::LIT_TOKEN_MASK) ==
                            lzwd_pkg::LIT_TOKEN_MASK) begin
                            r_lit_left <= i_byte[lzwd_pkg::LIT_W-1:0];
                            r_phase    <= lzwd_pkg::PH_LITERAL;
                        end else begin
                            r_code  <= i_byte;
                            r_phase <= lzwd_pkg::PH_DISTANCE;
                        end
                    end
                endcase
            end
            if (issue) begin
                r_iwp <= r_iwp + 1'b1;
                if (r_bp != lzwd_pkg::BP_MAX) begin
                    r_bp <= r_bp + 1'b1;
                end
            end
            if (copy_issue) begin
                r_len <= r_len - 1'b1;
            end
            if (adv) begin
                r_d_vld <= issue;
                r_d_fwd <= fwd_hit;
            end
        end
    end

    // data stage payload
    always_ff @(posedge i_clk) begin
        if (adv && issue) begin
            r_d_addr     <= r_iwp;
            r_d_lit      <= lit_issue;
            r_d_lit_byte <= i_byte;
            r_d_last     <= lit_issue || (r_len == lzwd_pkg::LEN_W'(1));
            r_d_zero     <= copy_issue && (r_dist > r_bp);
            r_fwd_data   <= d_value;
        end
    end

    `LZWD_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, r_d_vld && !i_pack_rdy,
        r_d_vld && $stable(r_d_addr), "data stage lost a byte under stall")
    `LZWD_ASSERT_IMP(a_fwd_copy_only, i_clk, i_rst_n, r_d_fwd,
        r_d_vld && !r_d_lit, "forwarding flagged outside a copy byte")
    `LZWD_ASSERT_IMP(a_ptr_order, i_clk, i_rst_n, r_d_vld,
        PW'(r_d_addr + 1'b1) == r_iwp, "history write pointer out of step")
    `LZWD_ASSERT_NXT(a_copy_starts, i_clk, i_rst_n,
        acc && (phase_eff == lzwd_pkg::PH_DISTANCE),
        r_len >= lzwd_pkg::COPY_MIN_LEN, "distance byte did not start a copy")

endmodule

`default_nettype wire

// ===== sv/lzwd_pack.sv =====
// byte packer and output register of the lz window decompressor
// depends on lzwd_pkg
`default_nettype none

module lzwd_pack #(
    parameter int BYTES_PER_RESULT = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire lzwd_pkg::t_byte                   i_byte,
    output logic                                   o_rdy,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [lzwd_pkg::OUT_DATA_W-1:0]        o_data,
    output logic [lzwd_pkg::OUT_COUNT_W-1:0]       o_count,
    output logic                                   o_last
);

    localparam int BW     = lzwd_pkg::BYTE_W;
    localparam int ACC_W  = BW * BYTES_PER_RESULT;
    localparam int FILL_W = $clog2(BYTES_PER_RESULT + 1);
    localparam int DW     = lzwd_pkg::OUT_DATA_W;
    localparam int CW     = lzwd_pkg::OUT_COUNT_W;

    logic [ACC_W-1:0]  r_acc;
    logic [FILL_W-1:0] r_fill;
    logic              r_o_vld;
    logic [DW-1:0]     r_o_data;
    logic [CW-1:0]     r_o_count;
    logic              r_o_last;

    logic [ACC_W-1:0]  word;
    logic [FILL_W:0]   count_full;
    logic              done;
    logic              out_rdy;
    logic              take;

    // lanes below the fill level keep their bytes, the new byte lands at
    // the fill level, everything above reads zero
    always_comb begin
        for (int j = 0; j < BYTES_PER_RESULT; j++) begin
            if (FILL_W'(j) < r_fill) begin
                word[j*BW +: BW] = r_acc[j*BW +: BW];
            end else if (FILL_W'(j) == r_fill) begin
                word[j*BW +: BW] = i_byte.data;
            end else begin
                word[j*BW +: BW] = '0;
            end
        end
    end

    assign count_full = {1'b0, r_fill} + 1'b1;
    assign done       = i_byte.last || (r_fill == FILL_W'(BYTES_PER_RESULT - 1));
    assign out_rdy    = !r_o_vld || i_ready;
    assign o_rdy      = !done || out_rdy;
    assign take       = i_byte.vld && o_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_o_vld <= 1'b0;
        end else begin
            if (r_o_vld && i_ready) begin
                r_o_vld <= 1'b0;
            end
            if (take) begin
                if (done) begin
                    r_o_vld <= 1'b1;
                    r_fill  <= '0;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_acc <= word;
            if (done) begin
                r_o_data  <= DW'(word);
                r_o_count <= CW'(count_full);
                r_o_last  <= i_byte.last;
            end
        end
    end

    assign o_valid = r_o_vld;
    assign o_data  = r_o_data;
    assign o_count = r_o_count;
    assign o_last  = r_o_last;

endmodule

`default_nettype wire

// ===== sv/lz_window_decompressor.sv =====
// top level of the lz window decompressor: stream ports around parser and packer
// depends on lzwd_pkg, lzwd_engine, lzwd_pack (and lzwd_ram below them)
//
// usage
//   slave channel: one compressed byte per transfer in s_tdata, s_tuser set on
//   the first byte of a new stream (drops any half-parsed token and restarts
//   the history count). master channel: up to BYTES_PER_RESULT decompressed
//   bytes per transfer, earliest byte lowest, with the byte count beside them;
//   m_tlast marks the final transfer caused by one input byte.
//   path: a literal byte goes through the data stage, then the output register;
//   token and length bytes give no output. throughput: while the packer does
//   not hold the data stage, token, length and literal bytes are taken one per
//   cycle, and a distance byte launches a copy of code+4 bytes that runs at one
//   byte per cycle through the single read port of the 256-byte history ram;
//   input is held off until the copy is issued, ceil((code+4)/BYTES_PER_RESULT)
//   results follow; a distance of one is served by forwarding the byte being
//   written. reset: synchronous, clears parser and pointers. the history
//   needs no clearing pass, since a copy only reads bytes written earlier in
//   the same stream and reads zero for anything further back.
//   stall: the output register holds while m_tready is low; once a completed
//   result is also waiting behind it the copy stops and s_tready drops
`default_nettype none

module lz_window_decompressor #(
    parameter int BYTES_PER_RESULT = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tuser,   // [0] stream_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] out_data, [34:32] out_count, rest zero
    output logic             m_tlast    // out_last
);

    lzwd_pkg::t_byte                      byte_s;
    logic                                 pack_rdy;
    logic [lzwd_pkg::OUT_DATA_W-1:0]      out_data;
    logic [lzwd_pkg::OUT_COUNT_W-1:0]     out_count;

    // parser, copy sequencer and history ram
    lzwd_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_tvalid),
        .o_ready    (s_tready),
        .i_byte     (s_tdata),
        .i_start    (s_tuser),
        .i_pack_rdy (pack_rdy),
        .o_byte     (byte_s)
    );

    // gathers bytes into results and decouples the master side
    lzwd_pack #(
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_s),
        .o_rdy   (pack_rdy),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (out_data),
        .o_count (out_count),
        .o_last  (m_tlast)
    );

    // pad the packed fields up to whole bytes
    assign m_tdata = {5'b0, out_count, out_data};

endmodule

`default_nettype wire
